FILE: design/psc_pkg.sv
// psc_pkg: shared types, constants and the crc-4 byte step for the
// pressure sensor compensation block; no dependencies
package psc_pkg;

	// calibration prom layout
	localparam int NUM_PROM  = 7;
	localparam int CFG_IDX_W = 3;
	localparam int PROM_W    = 16;

	// crc-4 constants
	localparam logic [15:0] CRC_POLY      = 16'h3000;
	localparam logic [15:0] CRC_BODY_MASK = 16'h0FFF;

	// compensation and window constants, hundredths of a degree and sensor units
	localparam int TEMP_BASE = 2000;
	localparam int TEMP_LO   = 1000;
	localparam int TEMP_HI   = 3000;
	localparam int PRES_LO   = 9000;
	localparam int PRES_HI   = 21000;

	typedef logic [NUM_PROM-1:0][PROM_W-1:0] prom_t;

	// status of the prom crc check
	typedef struct packed {
		logic busy;
		logic ok;
	} crc_stat_t;

	// eight shift steps of the crc remainder after one byte is folded in
	function automatic logic [15:0] crc_byte(input logic [15:0] rem_in);
		logic [15:0] r;
		r = rem_in;
		for (int i = 0; i < 8; i++) begin
			if (r[15]) begin
				r = {r[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

FILE: design/pressure_sensor_compensation.sv
// pressure_sensor_compensation: first-order compensation of raw pressure and
// temperature conversions with a prom crc-4 check; depends on psc_pkg, psc_crc4
//
// Takes one raw pressure / raw temperature pair per item and returns one
// result item: compensated temperature in hundredths of a degree, compensated
// pressure, the crc flag and the window flag. The datapath is an 8-stage
// pipeline (7 compute stages plus the output register), and one item is taken
// every cycle while the output side keeps up and no crc check is running; a
// held output fills the bubbles in the pipe before the input is stalled. The
// D1 x SENS product is split into two 17/18-bit partial products that are
// summed in the next stage. After reset and after every configuration write
// the crc unit walks the 16 prom bytes, one byte per cycle, and while it does
// so no input item is accepted.
module pressure_sensor_compensation (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psc_pkg::PROM_W-1:0]     cfg_data,
	// input items
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [47:0]                    s_axis_tdata,  // raw_pressure[23:0], raw_temperature[47:24]
	// result items
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [47:0]                    m_axis_tdata,  // temperature_centi[18:0], pressure_value[42:19], zero
	output logic [1:0]                     m_axis_tuser   // crc_ok[0], reading_ok[1]
);
	import psc_pkg::*;

	prom_t     prom_q;
	crc_stat_t crc_stat;
	logic      cfg_fire;
	logic      in_fire;

	// stage advance chain, bubbles collapse
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv_o;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic [23:0]        d1_s1, d1_s2, d1_s3;
	logic signed [24:0] dt_s1;
	logic signed [41:0] p3_s2, p4_s2, p6_s2;
	logic signed [35:0] off_s3, off_s4, off_s5;
	logic signed [34:0] sens_s3;
	logic signed [19:0] temp_s3, temp_s4, temp_s5, temp_s6, temp_s7;
	logic               tok_s4, tok_s5, tok_s6, tok_s7;
	logic [40:0]        pl_s4;
	logic signed [42:0] ph_s4;
	logic signed [59:0] prod_s5;
	logic signed [39:0] x_s6;
	logic signed [26:0] pres_s7;

	logic               out_vld_q;
	logic [18:0]        out_temp_q;
	logic [23:0]        out_pres_q;
	logic               out_crc_q;
	logic               out_rd_q;

	// combinational stage results
	logic signed [24:0] dt_c;
	logic signed [41:0] p3_t, p4_t, p6_t;
	logic signed [35:0] off_c;
	logic signed [34:0] sens_c;
	logic signed [19:0] temp_c;
	logic signed [59:0] prod_t;
	logic signed [38:0] q_c;
	logic signed [39:0] x_c;
	logic signed [39:0] x_t;
	logic signed [26:0] pres_c;
	logic               pres_ok;

	// configuration registers
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prom_q <= '0;
		end else if (cfg_fire && (int'(cfg_index) < NUM_PROM)) begin
			prom_q[cfg_index] <= cfg_data;
		end
	end

	psc_crc4 u_crc4 (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_fire),
		.prom    (prom_q),
		.stat    (crc_stat)
	);

	// handshake and advance chain
	assign adv_o = !out_vld_q || m_axis_tready;
	assign adv7  = !vld_s7 || adv_o;
	assign adv6  = !vld_s6 || adv7;
	assign adv5  = !vld_s5 || adv6;
	assign adv4  = !vld_s4 || adv5;
	assign adv3  = !vld_s3 || adv4;
	assign adv2  = !vld_s2 || adv3;
	assign adv1  = !vld_s1 || adv2;

	assign s_axis_tready = adv1 && !crc_stat.busy;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv1)  vld_s1    <= in_fire;
			if (adv2)  vld_s2    <= vld_s1;
			if (adv3)  vld_s3    <= vld_s2;
			if (adv4)  vld_s4    <= vld_s3;
			if (adv5)  vld_s5    <= vld_s4;
			if (adv6)  vld_s6    <= vld_s5;
			if (adv7)  vld_s7    <= vld_s6;
			if (adv_o) out_vld_q <= vld_s7;
		end
	end

	// stage 1: dT = D2 - C5 * 256
	assign dt_c = $signed({1'b0, s_axis_tdata[47:24]}) - $signed({1'b0, prom_q[5], 8'h00});

	always_ff @(posedge clk) begin
		if (adv1) begin
			d1_s1 <= s_axis_tdata[23:0];
			dt_s1 <= dt_c;
		end
	end

	// stage 2: coefficient products with dT
	always_ff @(posedge clk) begin
		if (adv2) begin
			d1_s2 <= d1_s1;
			p3_s2 <= dt_s1 * $signed({1'b0, prom_q[3]});
			p4_s2 <= dt_s1 * $signed({1'b0, prom_q[4]});
			p6_s2 <= dt_s1 * $signed({1'b0, prom_q[6]});
		end
	end

	// stage 3: OFF, SENS and TEMP with shifts that truncate toward zero
	always_comb begin
		p4_t   = p4_s2 + (p4_s2[41] ? 42'sd127 : 42'sd0);
		p3_t   = p3_s2 + (p3_s2[41] ? 42'sd255 : 42'sd0);
		p6_t   = p6_s2 + (p6_s2[41] ? 42'sd8388607 : 42'sd0);
		off_c  = $signed({4'b0, prom_q[2], 16'h0000}) + 36'(p4_t >>> 7);
		sens_c = $signed({4'b0, prom_q[1], 15'h0000}) + 35'(p3_t >>> 8);
		temp_c = 20'(TEMP_BASE) + 20'(p6_t >>> 23);
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			d1_s3   <= d1_s2;
			off_s3  <= off_c;
			sens_s3 <= sens_c;
			temp_s3 <= temp_c;
		end
	end

	// stage 4: D1 x SENS as two partial products, temperature window
	always_ff @(posedge clk) begin
		if (adv4) begin
			pl_s4   <= d1_s3 * sens_s3[16:0];
			ph_s4   <= $signed({1'b0, d1_s3}) * $signed(sens_s3[34:17]);
			off_s4  <= off_s3;
			temp_s4 <= temp_s3;
			tok_s4  <= (temp_s3 > 20'(TEMP_LO)) && (temp_s3 < 20'(TEMP_HI));
		end
	end

	// stage 5: combine partial products
	always_ff @(posedge clk) begin
		if (adv5) begin
			prod_s5 <= $signed({ph_s4, 17'h00000}) + $signed({19'b0, pl_s4});
			off_s5  <= off_s4;
			temp_s5 <= temp_s4;
			tok_s5  <= tok_s4;
		end
	end

	// stage 6: product / 2^21 minus OFF
	always_comb begin
		prod_t = prod_s5 + (prod_s5[59] ? 60'sd2097151 : 60'sd0);
		q_c    = 39'(prod_t >>> 21);
		x_c    = 40'(q_c) - 40'(off_s5);
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			x_s6    <= x_c;
			temp_s6 <= temp_s5;
			tok_s6  <= tok_s5;
		end
	end

	// stage 7: pressure = difference / 2^13
	always_comb begin
		x_t    = x_s6 + (x_s6[39] ? 40'sd8191 : 40'sd0);
		pres_c = 27'(x_t >>> 13);
	end

	always_ff @(posedge clk) begin
		if (adv7) begin
			pres_s7 <= pres_c;
			temp_s7 <= temp_s6;
			tok_s7  <= tok_s6;
		end
	end

	// output register with pressure window and crc flag
	assign pres_ok = (pres_s7 > 27'(PRES_LO)) && (pres_s7 < 27'(PRES_HI));

	always_ff @(posedge clk) begin
		if (adv_o) begin
			out_temp_q <= temp_s7[18:0];
			out_pres_q <= pres_s7[23:0];
			out_crc_q  <= crc_stat.ok;
			out_rd_q   <= crc_stat.ok && tok_s7 && pres_ok;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'b0, out_pres_q, out_temp_q};
	assign m_axis_tuser  = {out_rd_q, out_crc_q};

endmodule

FILE: design/psc_crc4.sv
// psc_crc4: byte-serial crc-4 check over the calibration prom words
// depends on psc_pkg
module psc_crc4 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               restart,
	input  psc_pkg::prom_t     prom,
	output psc_pkg::crc_stat_t stat
);
	import psc_pkg::*;

	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        ok_q;
	logic [15:0] rem_q;
	logic [15:0] word;
	logic [7:0]  byte_in;
	logic [15:0] rem_next;

	// pick the word and byte for the current step; the eighth word is zero
	always_comb begin
		case (cnt_q[3:1])
			3'd0: word = prom[0] & CRC_BODY_MASK;
			3'd1: word = prom[1];
			3'd2: word = prom[2];
			3'd3: word = prom[3];
			3'd4: word = prom[4];
			3'd5: word = prom[5];
			3'd6: word = prom[6];
			default: word = '0;
		endcase
		byte_in  = cnt_q[0] ? word[7:0] : word[15:8];
		rem_next = crc_byte(rem_q ^ {8'h00, byte_in});
	end

	// sixteen byte steps after reset and after every prom write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			ok_q   <= 1'b0;
			rem_q  <= '0;
		end else if (restart) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) begin
				busy_q <= 1'b0;
				ok_q   <= (rem_next[15:12] == prom[0][15:12]);
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.ok   = ok_q;

endmodule

FILE: tb/pressure_sensor_compensation_test.sv
// pressure_sensor_compensation_test: self-checking bench for the pressure and
// temperature compensation block, with its own compensation and crc-4 predictor
// depends on psc_pkg and pressure_sensor_compensation
`timescale 1ns / 1ps

module pressure_sensor_compensation_test;
	import psc_pkg::*;

	localparam logic [23:0] RAW_MAX        = 24'hFFFFFF;
	localparam longint      RAW_TOP        = 16777215;
	localparam int          STALL_LIMIT    = 1000;
	localparam int          RX_HOLD_CYCLES = 60;
	localparam int          DRAIN_TAIL     = 20;
	localparam int          RANDOM_PHASES  = 7;
	localparam int          PHASE_ITEMS    = 245;

	// prom register indexes, the last one is past the end of the prom
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROM0, REG_PROM1, REG_PROM2, REG_PROM3,
		REG_PROM4, REG_PROM5, REG_PROM6, REG_UNUSED
	} prom_reg_e;

	typedef logic [PROM_W-1:0] prom_set_t [NUM_PROM];

	typedef struct {
		logic signed [18:0] temperature_centi;
		logic signed [23:0] pressure_value;
		logic               crc_ok;
		logic               reading_ok;
	} reading_t;

	// compensation predictor and queue of expected readings
	class reading_checker;
		prom_set_t prom;
		reading_t  expected_readings [$];
		int        errors;
		int        n_results;
		int        n_crc_ok;
		int        n_reading_ok;

		function new();
			foreach (prom[k]) prom[k] = '0;
		endfunction

		function void write_prom(logic [CFG_IDX_W-1:0] idx, logic [PROM_W-1:0] value);
			if (idx < NUM_PROM) prom[idx] = value;
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction

		// crc-4 over the seven words and a zero word, the crc nibble masked off
		function logic [3:0] crc_of(prom_set_t words);
			logic [15:0] rem;
			logic [15:0] w;
			rem = '0;
			for (int n = 0; n < 16; n++) begin
				if (n / 2 == 0) begin
					w = words[0] & CRC_BODY_MASK;
				end else if (n / 2 < NUM_PROM) begin
					w = words[n / 2];
				end else begin
					w = '0;
				end
				rem = rem ^ ((n % 2) ? {8'h00, w[7:0]} : {8'h00, w[15:8]});
				for (int s = 0; s < 8; s++) begin
					rem = rem[15] ? ({rem[14:0], 1'b0} ^ CRC_POLY) : {rem[14:0], 1'b0};
				end
			end
			return rem[15:12];
		endfunction

		// first-order compensation, every division truncating toward zero
		function reading_t compensate(logic [23:0] raw_p, logic [23:0] raw_t);
			longint d1, d2, c1, c2, c3, c4, c5, c6;
			longint dt, off, sens, temp, pres;
			reading_t r;
			d1 = raw_p;
			d2 = raw_t;
			c1 = prom[REG_PROM1];
			c2 = prom[REG_PROM2];
			c3 = prom[REG_PROM3];
			c4 = prom[REG_PROM4];
			c5 = prom[REG_PROM5];
			c6 = prom[REG_PROM6];
			dt = d2 - c5 * 256;
			off = c2 * 65536 + (c4 * dt) / 128;
			sens = c1 * 32768 + (c3 * dt) / 256;
			temp = TEMP_BASE + (dt * c6) / 8388608;
			pres = ((d1 * sens) / 2097152 - off) / 8192;
			r.crc_ok = (prom[REG_PROM0][15:12] == crc_of(prom));
			r.temperature_centi = temp[18:0];
			r.pressure_value = pres[23:0];
			r.reading_ok = r.crc_ok && temp > TEMP_LO && temp < TEMP_HI
				&& pres > PRES_LO && pres < PRES_HI;
			return r;
		endfunction

		function longint level(bit on_pressure, longint x, logic [23:0] fixed_raw);
			reading_t r;
			if (on_pressure) begin
				r = compensate(x[23:0], fixed_raw);
				return r.pressure_value;
			end
			r = compensate(fixed_raw, x[23:0]);
			return r.temperature_centi;
		endfunction

		// raw value that brings pressure (or temperature) to the target, found by
		// interpolation and then a short walk; random when the curve is flat
		function logic [23:0] aim(bit on_pressure, logic [23:0] fixed_raw, longint target);
			longint lo, hi, x, v;
			lo = level(on_pressure, 0, fixed_raw);
			hi = level(on_pressure, 64'sd8388608, fixed_raw);
			if (hi <= lo) return 24'($urandom);
			x = ((target - lo) * 64'sd8388608) / (hi - lo);
			if (x < 0) x = 0;
			if (x > RAW_TOP) x = RAW_TOP;
			for (int k = 0; k < 64; k++) begin
				v = level(on_pressure, x, fixed_raw);
				if (v < target && x < RAW_TOP) begin
					x++;
				end else if (v > target && x > 0) begin
					x--;
				end else begin
					break;
				end
			end
			return x[23:0];
		endfunction

		function void note_item(logic [47:0] tdata);
			expected_readings.push_back(compensate(tdata[23:0], tdata[47:24]));
		endfunction

		function void check_result(logic [47:0] tdata, logic [1:0] tuser);
			reading_t want, got;
			got.temperature_centi = tdata[18:0];
			got.pressure_value = tdata[42:19];
			got.crc_ok = tuser[0];
			got.reading_ok = tuser[1];
			if (expected_readings.size() == 0) begin
				$error("result item with no input pending, tdata %h tuser %b", tdata, tuser);
				errors++;
				return;
			end
			want = expected_readings.pop_front();
			n_results++;
			if (want.crc_ok) n_crc_ok++;
			if (want.reading_ok) n_reading_ok++;
			if (got.temperature_centi !== want.temperature_centi) begin
				$error("temperature_centi mismatch: expected %0d, got %0d",
					want.temperature_centi, got.temperature_centi);
				errors++;
			end
			if (got.pressure_value !== want.pressure_value) begin
				$error("pressure_value mismatch: expected %0d, got %0d",
					want.pressure_value, got.pressure_value);
				errors++;
			end
			if (got.crc_ok !== want.crc_ok) begin
				$error("crc_ok mismatch: expected %0d, got %0d", want.crc_ok, got.crc_ok);
				errors++;
			end
			if (got.reading_ok !== want.reading_ok) begin
				$error("reading_ok mismatch: expected %0d, got %0d",
					want.reading_ok, got.reading_ok);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PROM_W-1:0]    cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [47:0]          s_axis_tdata;  // raw_pressure[23:0], raw_temperature[47:24]
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [47:0]          m_axis_tdata;  // temperature_centi[18:0], pressure_value[42:19], zero
	logic [1:0]           m_axis_tuser;  // crc_ok[0], reading_ok[1]

	reading_checker sb = new();
	bit rx_hold_req;
	bit steady;
	int burst_left;
	int n_items;
	int n_sets;
	int n_good_sets;
	int quiet_cycles;

	pressure_sensor_compensation dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// handshake monitor: results checked before the new item is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.write_prom(cfg_index, cfg_data);
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
			if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tdata);
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = steady ? 0 : $urandom_range(0, 4);
				if (gap != 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// one input item; valid stays high into the next item when no gap is drawn
	task automatic send_item(logic [23:0] raw_p, logic [23:0] raw_t);
		int gap;
		gap = (steady || burst_left != 0) ? 0 : $urandom_range(0, 4);
		if (burst_left != 0) burst_left--;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {raw_t, raw_p};
		do @(posedge clk); while (!s_axis_tready);
		n_items++;
	endtask

	// stop offering items until every expected reading is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_reg(prom_reg_e idx, logic [PROM_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// load a full prom set while idle, with a stray write past the prom first
	task automatic load_prom(prom_set_t words, bit seal_crc);
		if (seal_crc) words[REG_PROM0][15:12] = sb.crc_of(words);
		if (sb.crc_of(words) == words[REG_PROM0][15:12]) n_good_sets++;
		n_sets++;
		drain();
		write_reg(REG_UNUSED, 16'($urandom));
		for (int k = 0; k < NUM_PROM; k++) write_reg(prom_reg_e'(k), words[k]);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_random_prom(int flavor);
		prom_set_t words;
		foreach (words[k]) begin
			case (flavor)
				0: words[k] = 16'($urandom_range(16'h4000, 16'hB000));
				1: words[k] = 16'($urandom);
				default: begin
					case ($urandom_range(0, 2))
						0: words[k] = 16'h0000;
						1: words[k] = 16'hFFFF;
						default: words[k] = 16'($urandom);
					endcase
				end
			endcase
		end
		load_prom(words, flavor == 0 || $urandom_range(0, 3) != 0);
	endtask

	task automatic send_corners();
		send_item('0, '0);
		send_item(RAW_MAX, RAW_MAX);
		send_item('0, RAW_MAX);
		send_item(RAW_MAX, '0);
	endtask

	function automatic logic [23:0] corner_raw();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return RAW_MAX;
			2: return 24'(1) << $urandom_range(0, 23);
			default: return 24'($urandom);
		endcase
	endfunction

	// mostly readings aimed around the windows, the rest corners and noise
	task automatic send_random_item();
		logic [23:0] raw_t;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			raw_t = sb.aim(1'b0, RAW_MAX, $urandom_range(500, 3500));
			send_item(sb.aim(1'b1, raw_t, $urandom_range(7000, 23000)), raw_t);
		end else if (pick < 8) begin
			send_item(corner_raw(), corner_raw());
		end else begin
			send_item(24'($urandom), 24'($urandom));
		end
	endtask

	initial begin
		prom_set_t typical;
		prom_set_t flat;
		logic [23:0] dt_zero;
		logic [23:0] raw_t;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_PROM0;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// prom still at reset: all zero, crc of zeros matches
		send_corners();

		// a typical calibration with a good crc
		typical = '{16'h0000, 16'd34982, 16'd36352, 16'd20328, 16'd22268, 16'd26646, 16'd26146};
		load_prom(typical, 1'b1);
		send_corners();
		// zero and slightly negative dT, where rounding toward zero matters
		dt_zero = {typical[REG_PROM5], 8'h00};
		send_item(24'h4BA7E3, dt_zero);
		send_item(24'h4BA7E3, dt_zero - 24'd1);
		send_item(24'h4BA7E3, dt_zero - 24'd12345);
		// readings on and just inside the window bounds
		raw_t = sb.aim(1'b0, '0, TEMP_BASE);
		send_item(sb.aim(1'b1, raw_t, 15000), raw_t);
		send_item(sb.aim(1'b1, raw_t, PRES_LO), raw_t);
		send_item(sb.aim(1'b1, raw_t, PRES_HI), raw_t);
		send_item(sb.aim(1'b1, raw_t, PRES_HI - 1), raw_t);
		raw_t = sb.aim(1'b0, '0, TEMP_LO);
		send_item(sb.aim(1'b1, raw_t, 15000), raw_t);
		raw_t = sb.aim(1'b0, '0, TEMP_HI);
		send_item(sb.aim(1'b1, raw_t, 15000), raw_t);
		raw_t = sb.aim(1'b0, '0, TEMP_LO + 1);
		send_item(sb.aim(1'b1, raw_t, PRES_LO + 1), raw_t);

		// every word at its maximum, crc left as it falls
		foreach (flat[k]) flat[k] = 16'hFFFF;
		load_prom(flat, 1'b0);
		send_corners();

		// every word written as zero
		foreach (flat[k]) flat[k] = 16'h0000;
		load_prom(flat, 1'b0);
		send_corners();

		// random calibration phases
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			load_random_prom(ph % 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				steady = (ph == 3 && i < 120);
				// long receiver hold-off while the sender keeps pushing
				if (ph == 1 && i == 60) begin
					rx_hold_req = 1'b1;
					burst_left = 40;
				end
				if (ph == 2 && i == 120) drain();
				send_random_item();
			end
		end
		steady = 1'b0;

		drain();
		repeat (DRAIN_TAIL) @(posedge clk);
		$display("covered %0d input items over %0d calibration sets (%0d with a matching crc)",
			n_items, n_sets, n_good_sets);
		$display("%0d readings checked, %0d with crc pass, %0d inside both windows, %0d errors",
			sb.n_results, sb.n_crc_ok, sb.n_reading_ok, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
